>>> sv/jaae_pkg.sv
// ----------------------------------------------------------------------------
// jaae_pkg
// Shared constants, probability estimation tables and the command and status
// records that pass between the encoder controller and its datapath.
// ----------------------------------------------------------------------------
package jaae_pkg;

  localparam int CONTEXTS          = 1024;
  localparam int ESTIMATION_STATES = 113;
  localparam int FILL_COUNT_MAX    = 65535;

  localparam int CTX_W = $clog2(CONTEXTS);
  localparam int ST_W  = 7;
  localparam int A_W   = 17;
  localparam int C_W   = 28;
  localparam int CT_W  = 4;
  localparam int SC_W  = 16;
  localparam int CF_W  = 29;
  localparam int CX_W  = CF_W + 16;

  localparam logic [1:0] OP_ENCODE = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  localparam logic [A_W-1:0]  A_INIT  = 17'h10000;
  localparam logic [CT_W-1:0] CT_INIT = 4'd11;
  localparam logic [CT_W-1:0] CT_BYTE = 4'd8;

  localparam logic [15:0] LSZ_TAB [ESTIMATION_STATES] = '{
    16'h5a1d, 16'h2586, 16'h1114, 16'h080b, 16'h03d8, 16'h01da, 16'h00e5, 16'h006f,
    16'h0036, 16'h001a, 16'h000d, 16'h0006, 16'h0003, 16'h0001, 16'h5a7f, 16'h3f25,
    16'h2cf2, 16'h207c, 16'h17b9, 16'h1182, 16'h0cef, 16'h09a1, 16'h072f, 16'h055c,
    16'h0406, 16'h0303, 16'h0240, 16'h01b1, 16'h0144, 16'h00f5, 16'h00b7, 16'h008a,
    16'h0068, 16'h004e, 16'h003b, 16'h002c, 16'h5ae1, 16'h484c, 16'h3a0d, 16'h2ef1,
    16'h261f, 16'h1f33, 16'h19a8, 16'h1518, 16'h1177, 16'h0e74, 16'h0bfb, 16'h09f8,
    16'h0861, 16'h0706, 16'h05cd, 16'h04de, 16'h040f, 16'h0363, 16'h02d4, 16'h025c,
    16'h01f8, 16'h01a4, 16'h0160, 16'h0125, 16'h00f6, 16'h00cb, 16'h00ab, 16'h008f,
    16'h5b12, 16'h4d04, 16'h412c, 16'h37d8, 16'h2fe8, 16'h293c, 16'h2379, 16'h1edf,
    16'h1aa9, 16'h174e, 16'h1424, 16'h119c, 16'h0f6b, 16'h0d51, 16'h0bb6, 16'h0a40,
    16'h5832, 16'h4d1c, 16'h438e, 16'h3bdd, 16'h34ee, 16'h2eae, 16'h299a, 16'h2516,
    16'h5570, 16'h4ca9, 16'h44d9, 16'h3e22, 16'h3824, 16'h32b4, 16'h2e17, 16'h56a8,
    16'h4f46, 16'h47e5, 16'h41cf, 16'h3c3d, 16'h375e, 16'h5231, 16'h4c0f, 16'h4639,
    16'h415e, 16'h5627, 16'h50e7, 16'h4b85, 16'h5597, 16'h504f, 16'h5a10, 16'h5522,
    16'h59eb
  };

  localparam logic [ST_W-1:0] NMPS_TAB [ESTIMATION_STATES] = '{
    7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7, 7'd8, 7'd9, 7'd10, 7'd11, 7'd12,
    7'd13, 7'd13, 7'd15, 7'd16, 7'd17, 7'd18, 7'd19, 7'd20, 7'd21, 7'd22, 7'd23,
    7'd24, 7'd25, 7'd26, 7'd27, 7'd28, 7'd29, 7'd30, 7'd31, 7'd32, 7'd33, 7'd34,
    7'd35, 7'd9, 7'd37, 7'd38, 7'd39, 7'd40, 7'd41, 7'd42, 7'd43, 7'd44, 7'd45,
    7'd46, 7'd47, 7'd48, 7'd49, 7'd50, 7'd51, 7'd52, 7'd53, 7'd54, 7'd55, 7'd56,
    7'd57, 7'd58, 7'd59, 7'd60, 7'd61, 7'd62, 7'd63, 7'd32, 7'd65, 7'd66, 7'd67,
    7'd68, 7'd69, 7'd70, 7'd71, 7'd72, 7'd73, 7'd74, 7'd75, 7'd76, 7'd77, 7'd78,
    7'd79, 7'd48, 7'd81, 7'd82, 7'd83, 7'd84, 7'd85, 7'd86, 7'd87, 7'd71, 7'd89,
    7'd90, 7'd91, 7'd92, 7'd93, 7'd94, 7'd86, 7'd96, 7'd97, 7'd98, 7'd99, 7'd100,
    7'd93, 7'd102, 7'd103, 7'd104, 7'd99, 7'd106, 7'd107, 7'd103, 7'd109, 7'd107,
    7'd111, 7'd109, 7'd111
  };

  localparam logic [ST_W-1:0] NLPS_TAB [ESTIMATION_STATES] = '{
    7'd1, 7'd14, 7'd16, 7'd18, 7'd20, 7'd23, 7'd25, 7'd28, 7'd30, 7'd33, 7'd35,
    7'd9, 7'd10, 7'd12, 7'd15, 7'd36, 7'd38, 7'd39, 7'd40, 7'd42, 7'd43, 7'd45,
    7'd46, 7'd48, 7'd49, 7'd51, 7'd52, 7'd54, 7'd56, 7'd57, 7'd59, 7'd60, 7'd62,
    7'd63, 7'd32, 7'd33, 7'd37, 7'd64, 7'd65, 7'd67, 7'd68, 7'd69, 7'd70, 7'd72,
    7'd73, 7'd74, 7'd75, 7'd77, 7'd78, 7'd79, 7'd48, 7'd50, 7'd50, 7'd51, 7'd52,
    7'd53, 7'd54, 7'd55, 7'd56, 7'd57, 7'd58, 7'd59, 7'd61, 7'd61, 7'd65, 7'd80,
    7'd81, 7'd82, 7'd83, 7'd84, 7'd86, 7'd87, 7'd87, 7'd72, 7'd72, 7'd74, 7'd74,
    7'd75, 7'd77, 7'd77, 7'd80, 7'd88, 7'd89, 7'd90, 7'd91, 7'd92, 7'd93, 7'd86,
    7'd88, 7'd95, 7'd96, 7'd97, 7'd99, 7'd99, 7'd93, 7'd95, 7'd101, 7'd102,
    7'd103, 7'd104, 7'd99, 7'd105, 7'd106, 7'd107, 7'd103, 7'd105, 7'd108,
    7'd109, 7'd110, 7'd111, 7'd110, 7'd112, 7'd112
  };

  function automatic logic mps_switch(input logic [ST_W-1:0] st);
    logic sw;
    case (st) inside
      7'd0, 7'd14, 7'd36, 7'd64, 7'd80, 7'd88, 7'd95, 7'd105, 7'd110, 7'd112: sw = 1'b1;
      default: sw = 1'b0;
    endcase
    return sw;
  endfunction

  typedef struct packed {
    logic accept;
    logic clr_step;
    logic enc_eval;
    logic ren_step;
    logic fl_prep;
    logic fl_lead;
    logic fl_b1;
    logic fl_b2;
    logic push_last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic need_renorm;
    logic renorm_done;
    logic clr_last;
    logic pend_valid;
  } sts_t;

endpackage

>>> sv/jaae_ram.sv
// ----------------------------------------------------------------------------
// jaae_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module jaae_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/jaae_ctrl.sv
// ----------------------------------------------------------------------------
// jaae_ctrl
// Sequencer for the encoder: context clearing, pixel coding with
// renormalization, stripe flush and delivery of the final result.
// ----------------------------------------------------------------------------
module jaae_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [1:0]     opcode,
  input  logic           reset_contexts,
  output logic           in_stall,
  input  jaae_pkg::sts_t sts,
  output jaae_pkg::cmd_t cmd
);

  typedef enum logic [8:0] {
    S_CLR  = 9'b000000001,
    S_IDLE = 9'b000000010,
    S_ENC  = 9'b000000100,
    S_REN  = 9'b000001000,
    S_FL1  = 9'b000010000,
    S_FL2  = 9'b000100000,
    S_FL3  = 9'b001000000,
    S_FL4  = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (opcode)
            jaae_pkg::OP_ENCODE: state_next = S_ENC;
            jaae_pkg::OP_START:  state_next = reset_contexts ? S_CLR : S_IDLE;
            jaae_pkg::OP_FLUSH:  state_next = S_FL1;
            default:             state_next = S_IDLE;
          endcase
        end
      end
      S_ENC: begin
        cmd.enc_eval = 1'b1;
        state_next   = sts.need_renorm ? S_REN : S_FIN;
      end
      S_REN: begin
        // A step may produce a byte, so it waits for room at the output.
        if (sts.out_free) begin
          cmd.ren_step = 1'b1;
          if (sts.renorm_done) begin
            state_next = S_FIN;
          end
        end
      end
      S_FL1: begin
        cmd.fl_prep = 1'b1;
        state_next  = S_FL2;
      end
      S_FL2: begin
        if (sts.out_free) begin
          cmd.fl_lead = 1'b1;
          state_next  = S_FL3;
        end
      end
      S_FL3: begin
        if (sts.out_free) begin
          cmd.fl_b1  = 1'b1;
          state_next = S_FL4;
        end
      end
      S_FL4: begin
        if (sts.out_free) begin
          cmd.fl_b2  = 1'b1;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!sts.pend_valid) begin
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          cmd.push_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> sv/jaae_dp.sv
// ----------------------------------------------------------------------------
// jaae_dp
// Coder datapath: interval and code registers, context store, byte output
// with carry and 0xFF stacking, and the result buffer.
// ----------------------------------------------------------------------------
module jaae_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  jaae_pkg::cmd_t             cmd,
  output jaae_pkg::sts_t             sts,
  input  logic [1:0]                 opcode,
  input  logic                       pixel,
  input  logic [jaae_pkg::CTX_W-1:0] context_req,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       lead_valid,
  output logic [7:0]                 lead_byte,
  output logic                       fill_is_ff,
  output logic [15:0]                fill_count,
  output logic                       last
);

  // Coder registers.
  logic [jaae_pkg::A_W-1:0]   interval;
  logic [jaae_pkg::C_W-1:0]   code_low;
  logic [jaae_pkg::CT_W-1:0]  shift_count;
  logic [jaae_pkg::SC_W-1:0]  stacked;
  logic [7:0]                 held_byte;
  logic                       first_pending;
  logic [jaae_pkg::CF_W-1:0]  code_fl;
  logic                       pix_q;
  logic [jaae_pkg::CTX_W-1:0] idx_q;
  logic [jaae_pkg::CTX_W-1:0] clr_addr;

  // Pending result, held until it is known whether another one follows.
  logic       pend_valid;
  logic       pend_lv;
  logic [7:0] pend_lead;
  logic       pend_ff;
  logic [15:0] pend_cnt;

  // Context store.
  logic                       ram_we;
  logic [jaae_pkg::CTX_W-1:0] ram_waddr;
  logic [7:0]                 ram_wdata;
  logic [7:0]                 ram_rdata;

  jaae_ram #(.WIDTH(8), .DEPTH(jaae_pkg::CONTEXTS)) u_ctx (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (context_req),
    .rdata (ram_rdata)
  );

  function automatic logic [4:0] lzc16(input logic [15:0] v);
    logic [4:0] n;
    n = 5'd16;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) begin
        n = 5'(15 - i);
      end
    end
    return n;
  endfunction

  // Pixel evaluation.
  logic [jaae_pkg::ST_W-1:0] st_raw, st, st_new;
  logic                      mps, mps_new;
  logic [jaae_pkg::A_W-1:0]  lsz, a_sub, a_enc;
  logic [jaae_pkg::C_W-1:0]  c_enc;
  logic                      need_renorm;

  always_comb begin
    st_raw      = ram_rdata[6:0];
    mps         = ram_rdata[7];
    st          = (st_raw >= 7'(jaae_pkg::ESTIMATION_STATES)) ? '0 : st_raw;
    lsz         = {1'b0, jaae_pkg::LSZ_TAB[st]};
    a_sub       = interval - lsz;
    a_enc       = a_sub;
    c_enc       = code_low;
    st_new      = st;
    mps_new     = mps;
    need_renorm = 1'b0;
    if (pix_q == mps) begin
      if (a_sub < 17'h08000) begin
        if (a_sub < lsz) begin
          c_enc = code_low + {11'd0, a_sub};
          a_enc = lsz;
        end
        st_new      = jaae_pkg::NMPS_TAB[st];
        need_renorm = 1'b1;
      end
    end else begin
      if (a_sub >= lsz) begin
        c_enc = code_low + {11'd0, a_sub};
        a_enc = lsz;
      end
      mps_new     = mps ^ jaae_pkg::mps_switch(st);
      st_new      = jaae_pkg::NLPS_TAB[st];
      need_renorm = 1'b1;
    end
  end

  // One renormalization step shifts up to the next byte boundary.
  logic [4:0]                n_sh, k_sh;
  logic [jaae_pkg::A_W-1:0]  a_sh;
  logic [jaae_pkg::C_W-1:0]  c_sh;
  logic [jaae_pkg::CT_W-1:0] ct_sh;
  logic [8:0]                tbyte;

  always_comb begin
    n_sh  = lzc16(interval[15:0]);
    k_sh  = (n_sh < {1'b0, shift_count}) ? n_sh : {1'b0, shift_count};
    a_sh  = interval << k_sh;
    c_sh  = code_low << k_sh;
    ct_sh = shift_count - k_sh[jaae_pkg::CT_W-1:0];
    tbyte = c_sh[jaae_pkg::C_W-1:19];
  end

  // Flush arithmetic.
  logic [jaae_pkg::CF_W-1:0] fl_sum, fl_t, fl_c;
  logic [jaae_pkg::CX_W-1:0] c_x;
  logic                      c_big;

  always_comb begin
    fl_sum = {12'd0, interval} + {1'b0, code_low} - 29'd1;
    fl_t   = {fl_sum[jaae_pkg::CF_W-1:16], 16'd0};
    fl_c   = (fl_t < {1'b0, code_low}) ? fl_t + 29'h8000 : fl_t;
    c_x    = {16'd0, code_fl} << shift_count;
    c_big  = |c_x[jaae_pkg::CX_W-1:27];
  end

  // Result source selection.
  logic       emit;
  logic [7:0] e_lead;
  logic       e_ff;
  logic [15:0] e_cnt;
  logic       bo_emit;

  always_comb begin
    bo_emit = cmd.ren_step && (ct_sh == '0) && (tbyte != 9'h0ff);
    emit    = bo_emit || cmd.fl_lead || cmd.fl_b1 || cmd.fl_b2;
    e_lead  = held_byte;
    e_ff    = 1'b1;
    e_cnt   = stacked;
    if (cmd.fl_b1) begin
      e_lead = c_x[26:19];
      e_ff   = 1'b0;
      e_cnt  = '0;
    end else if (cmd.fl_b2) begin
      e_lead = c_x[18:11];
      e_ff   = 1'b0;
      e_cnt  = '0;
    end else if ((cmd.fl_lead && c_big) || (cmd.ren_step && tbyte[8])) begin
      e_lead = held_byte + 8'd1;
      e_ff   = 1'b0;
    end
  end

  always_comb begin
    ram_we    = cmd.clr_step || cmd.enc_eval;
    ram_waddr = cmd.clr_step ? clr_addr : idx_q;
    ram_wdata = cmd.clr_step ? 8'd0 : {mps_new, st_new};
  end

  assign sts.out_free    = !out_valid || !out_stall;
  assign sts.need_renorm = need_renorm;
  assign sts.renorm_done = (k_sh == n_sh);
  assign sts.clr_last    = (clr_addr == jaae_pkg::CTX_W'(jaae_pkg::CONTEXTS - 1));
  assign sts.pend_valid  = pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval      <= jaae_pkg::A_INIT;
      code_low      <= '0;
      shift_count   <= jaae_pkg::CT_INIT;
      stacked       <= '0;
      held_byte     <= '0;
      first_pending <= 1'b1;
      clr_addr      <= '0;
      pend_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.accept) begin
        pix_q <= pixel;
        idx_q <= context_req;
        if (opcode == jaae_pkg::OP_START) begin
          interval      <= jaae_pkg::A_INIT;
          code_low      <= '0;
          shift_count   <= jaae_pkg::CT_INIT;
          stacked       <= '0;
          held_byte     <= '0;
          first_pending <= 1'b1;
          clr_addr      <= '0;
        end
      end
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.enc_eval) begin
        interval <= a_enc;
        code_low <= c_enc;
      end
      if (cmd.ren_step) begin
        interval <= a_sh;
        if (ct_sh == '0) begin
          code_low    <= {9'd0, c_sh[18:0]};
          shift_count <= jaae_pkg::CT_BYTE;
          if (tbyte == 9'h0ff) begin
            if (stacked != jaae_pkg::SC_W'(jaae_pkg::FILL_COUNT_MAX)) begin
              stacked <= stacked + 1'b1;
            end
          end else begin
            stacked   <= '0;
            held_byte <= tbyte[7:0];
          end
        end else begin
          code_low    <= c_sh;
          shift_count <= ct_sh;
        end
      end
      if (cmd.fl_prep) begin
        code_fl <= fl_c;
      end
      if (cmd.fl_lead) begin
        stacked <= '0;
      end
      if (cmd.fl_b2) begin
        code_low <= c_x[jaae_pkg::C_W-1:0];
      end

      // Output register and pending buffer.
      if ((emit && pend_valid) || cmd.push_last) begin
        out_valid  <= 1'b1;
        lead_valid <= pend_lv;
        lead_byte  <= pend_lead;
        fill_is_ff <= pend_ff;
        fill_count <= pend_cnt;
        last       <= cmd.push_last;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        pend_valid    <= 1'b1;
        pend_lv       <= !first_pending;
        pend_lead     <= e_lead;
        pend_ff       <= e_ff;
        pend_cnt      <= e_cnt;
        first_pending <= cmd.fl_b2;
      end else if (cmd.push_last) begin
        pend_valid <= 1'b0;
      end
    end
  end

endmodule

>>> sv/jbig_adaptive_arithmetic_encoder_unit.sv
// ----------------------------------------------------------------------------
// jbig_adaptive_arithmetic_encoder_unit
// T.82 adaptive binary arithmetic encoder with carry and 0xFF run reporting.
// ----------------------------------------------------------------------------
// An encode request reads its context, evaluates the pixel and writes the
//   context back, then runs renormalization steps (at most 3 steps, one per
//   byte boundary); a flush prepares the code, then emits three results.
// After reset, and after a start request that clears contexts, a clearing
//   pass writes all 1024 entries of the context store before new requests.
// ----------------------------------------------------------------------------
module jbig_adaptive_arithmetic_encoder_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 opcode,
  input  logic                       pixel,
  input  logic [jaae_pkg::CTX_W-1:0] context_req,
  input  logic                       reset_contexts,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       lead_valid,
  output logic [7:0]                 lead_byte,
  output logic                       fill_is_ff,
  output logic [15:0]                fill_count,
  output logic                       last
);

  jaae_pkg::cmd_t cmd;
  jaae_pkg::sts_t sts;

  jaae_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .opcode         (opcode),
    .reset_contexts (reset_contexts),
    .in_stall       (in_stall),
    .sts            (sts),
    .cmd            (cmd)
  );

  jaae_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .opcode      (opcode),
    .pixel       (pixel),
    .context_req (context_req),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .lead_valid  (lead_valid),
    .lead_byte   (lead_byte),
    .fill_is_ff  (fill_is_ff),
    .fill_count  (fill_count),
    .last        (last)
  );

endmodule
